/* rtl/smpq_pkg.sv */
// Shared types and constants for the sorted-array min-priority queue.
package smpq_pkg;

    localparam int DATA_W       = 32;
    localparam int OCC_W        = 11;
    localparam int CAPACITY_DEF = 1024;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef logic signed [DATA_W-1:0] data_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic  insert;
        logic  remove;
        data_t value;
    } cell_ctrl_t;

endpackage

/* rtl/smpq_cell.sv */
// One storage cell of the sorted chain: holds an entry, compares, shifts.
module smpq_cell (
    input  logic                clk,
    input  smpq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  smpq_pkg::data_t     left_entry,
    input  logic                left_gt,
    input  smpq_pkg::data_t     right_entry,
    output smpq_pkg::data_t     entry,
    output logic                gt
);
    import smpq_pkg::*;

    data_t entry_reg;
    data_t entry_next;

    // Slot lies at or after the insert position.
    assign gt    = !occupied || (entry_reg > ctrl.value);
    assign entry = entry_reg;

    always_comb
    begin
        priority if (ctrl.remove)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.insert && gt)
        begin
            entry_next = left_gt ? left_entry : ctrl.value;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/sorted_array_min_priority_queue.sv */
// Min-priority queue built as a chain of compare-and-shift cells.
// One transaction is accepted per clock while in_ready is high: mode 0 inserts value at
// its sorted place (after equal values), mode 1 removes and returns the smallest entry.
// Every cell compares its entry with the broadcast value and shifts toward its neighbor in
// the same cycle, so an operation's result is registered on the output the cycle after
// acceptance. Input is taken whenever the output register is empty or being drained.
// Status 2 reports removal from an empty queue, status 3 insertion into a full one; neither
// changes the contents. occupancy is the entry count after the operation, low 11 bits.
module sorted_array_min_priority_queue #(
    parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  smpq_pkg::data_t               value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output smpq_pkg::data_t               removed_value,
    output logic [1:0]                    status,
    output logic [smpq_pkg::OCC_W-1:0]    occupancy
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    data_t            removed_reg;
    status_t          status_reg;
    logic [OCC_W-1:0] occ_reg;
    data_t            removed_next;
    status_t          status_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;

    data_t entries [CAPACITY];
    logic  gts     [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign ctrl.insert = accept && (mode == MODE_INSERT) && !is_full;
    assign ctrl.remove = accept && (mode == MODE_REMOVE) && !is_empty;
    assign ctrl.value  = value;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            data_t left_entry;
            logic  left_gt;
            data_t right_entry;

            if (i == 0)
            begin : g_first
                assign left_entry = value;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_mid
                assign left_entry = entries[i-1];
                assign left_gt    = gts[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_entry = entries[i];
            end
            else
            begin : g_inner
                assign right_entry = entries[i+1];
            end

            smpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (count_reg > CNT_W'(i)),
                .left_entry  (left_entry),
                .left_gt     (left_gt),
                .right_entry (right_entry),
                .entry       (entries[i]),
                .gt          (gts[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        removed_next = '0;
        if (mode == MODE_INSERT)
        begin
            status_next = is_full ? ST_FULL : ST_INSERTED;
            if (!is_full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            status_next = is_empty ? ST_EMPTY : ST_REMOVED;
            if (!is_empty)
            begin
                count_next   = count_reg - CNT_W'(1);
                removed_next = entries[0];
            end
        end
    end

    always_comb
    begin
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg <= removed_next;
            status_reg  <= status_next;
            occ_reg     <= OCC_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign occupancy     = occ_reg;

endmodule

/* rtl/smpq_checker.sv */
// Port-level assertions for the priority queue, bound to the top level.
module smpq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input smpq_pkg::data_t            removed_value,
    input logic [1:0]                 status,
    input logic [smpq_pkg::OCC_W-1:0] occupancy
);
    import smpq_pkg::*;

    // Output held while stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(removed_value)
            && $stable(status) && $stable(occupancy))
        else $error("stalled result changed");

    // Every accepted transaction yields a result next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted transaction produced no result");

    // Input is never blocked while the output stage is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // Only a successful removal returns a value.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_REMOVED) |-> removed_value == '0)
        else $error("nonzero value without removal");

    // Empty report means zero occupancy.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> occupancy == '0)
        else $error("empty status with nonzero occupancy");

endmodule

bind sorted_array_min_priority_queue smpq_checker u_smpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .removed_value (removed_value),
    .status        (status),
    .occupancy     (occupancy)
);

/* dv/smpq_result_checker.sv */
// Result checker for the min-priority queue: tracks the queue contents and compares every output.
module smpq_result_checker
    import smpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             mode,
    input  data_t            value,
    input  logic             out_valid,
    input  logic             out_ready,
    input  data_t            removed_value,
    input  logic [1:0]       status,
    input  logic [OCC_W-1:0] occupancy,
    output int               errors,
    output int               awaiting
);

    typedef struct {
        data_t            removed;
        status_t          st;
        logic [OCC_W-1:0] occ;
    } op_result_t;

    data_t      queued_values[$];
    op_result_t awaited_results[$];
    int         mismatch_count = 0;
    int         awaited_count  = 0;

    assign errors   = mismatch_count;
    assign awaiting = awaited_count;

    // equal values keep arrival order: a new value goes after its equals
    function automatic op_result_t apply_op(input logic m, input data_t v);
        op_result_t r;
        int         pos;
        r.removed = '0;
        if (m == MODE_INSERT) begin
            if (queued_values.size() >= CAPACITY) begin
                r.st = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < queued_values.size() && queued_values[pos] <= v)
                    pos++;
                queued_values.insert(pos, v);
                r.st = ST_INSERTED;
            end
        end
        else if (queued_values.size() == 0) begin
            r.st = ST_EMPTY;
        end
        else begin
            r.removed = queued_values.pop_front();
            r.st      = ST_REMOVED;
        end
        r.occ = OCC_W'(queued_values.size());
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        op_result_t exp_r;
        if (rst_n)
        begin
            // drain side first: a transaction's result never leaves in its own cycle
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t unexpected result: removed_value %0d status %0d occupancy %0d",
                             $time, removed_value, status, occupancy);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (removed_value !== exp_r.removed)
                    begin
                        $display("%0t removed_value: expected %0d actual %0d",
                                 $time, exp_r.removed, removed_value);
                        mismatch_count++;
                    end
                    if (status !== exp_r.st)
                    begin
                        $display("%0t status: expected %0d actual %0d",
                                 $time, exp_r.st, status);
                        mismatch_count++;
                    end
                    if (occupancy !== exp_r.occ)
                    begin
                        $display("%0t occupancy: expected %0d actual %0d",
                                 $time, exp_r.occ, occupancy);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(apply_op(mode, value));
            awaited_count = awaited_results.size();
        end
    end

endmodule

/* dv/tb_sorted_array_min_priority_queue.sv */
// Testbench top for the min-priority queue: clock, reset, stimulus, flow control and verdict.
module tb_sorted_array_min_priority_queue;
    import smpq_pkg::*;

    localparam int QCAP = CAPACITY_DEF;

    localparam data_t EDGE_VALS [11] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'd5, 32'd5,
        32'd5, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             mode;
    data_t            value;
    logic             out_valid;
    logic             out_ready;
    data_t            removed_value;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;

    int fail_count;
    int awaiting;
    bit idle_on = 1'b1;
    int level   = 0;
    int drained = 0;
    bit held_once = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sorted_array_min_priority_queue #(
        .CAPACITY (QCAP)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_value),
        .status        (status),
        .occupancy     (occupancy)
    );

    smpq_result_checker #(
        .CAPACITY (QCAP)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_value),
        .status        (status),
        .occupancy     (occupancy),
        .errors        (fail_count),
        .awaiting      (awaiting)
    );

    function automatic data_t pick_value();
        case ($urandom_range(0, 5))
            0: return data_t'($urandom_range(0, 16)) - 8;
            1:
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            default: return data_t'($urandom);
        endcase
    endfunction

    // offer one transaction and wait for its acceptance; valid stays up afterwards
    task automatic push_op(input logic m, input data_t v);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (m == MODE_INSERT)
        begin
            if (level < QCAP)
                level++;
        end
        else if (level > 0)
        begin
            level--;
        end
    endtask

    // output side: random stalls, plus one long hold-off to back the queue up
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                drained++;
            if (!held_once && drained >= 150)
            begin
                held_once = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int k;
        int ins_pct;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        mode     <= MODE_INSERT;
        value    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // removal from empty, extremes, duplicates, drain back to empty
        push_op(MODE_REMOVE, 32'hFFFF_FFFF);
        foreach (EDGE_VALS[i])
            push_op(MODE_INSERT, EDGE_VALS[i]);
        repeat (11) push_op(MODE_REMOVE, data_t'($urandom));
        push_op(MODE_REMOVE, 32'h7FFF_FFFF);

        for (k = 0; k < 480; k++)
        begin
            idle_on = ((k / 100) % 3 != 2);
            ins_pct = (level < 8) ? 70 : (level > 60) ? 35 : 55;
            if ($urandom_range(0, 99) < ins_pct)
                push_op(MODE_INSERT, pick_value());
            else
                push_op(MODE_REMOVE, data_t'($urandom));
        end

        // full-rate tail: churn with no idling
        idle_on = 1'b0;
        repeat (40)
        begin
            if ($urandom_range(0, 3) == 0)
                push_op(MODE_INSERT, pick_value());
            else
                push_op(MODE_REMOVE, data_t'($urandom));
        end
        in_valid <= 1'b0;

        while (awaiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
